// ===== src/lcp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcp_pkg
// Shared types and constants of the LZW compressor with variable-width
// code packing.
// ---------------------------------------------------------------------------
package lcp_pkg;

   localparam int MAX_CODE_BITS = 12;

   localparam int CLEAR_CODE  = 256;
   localparam int FIRST_FREE  = 257;
   localparam int MIN_WIDTH   = 9;

   localparam int IDX_W       = MAX_CODE_BITS + 8;
   localparam int TABLE_DEPTH = 1 << IDX_W;
   localparam int NFC_W       = MAX_CODE_BITS + 1;
   localparam int CW_W        = $clog2(MAX_CODE_BITS + 1);
   localparam int EPOCH_W     = 10;

   localparam int HDR_LEN     = 24;
   localparam logic [HDR_LEN-1:0] HDR_BITS = {8'(128 + MAX_CODE_BITS), 8'h9D, 8'h1F};

   // worst-case bits one request appends before padding
   localparam int ITEM_W  = (3 * MAX_CODE_BITS > HDR_LEN + MIN_WIDTH) ?
                            3 * MAX_CODE_BITS : HDR_LEN + MIN_WIDTH;
   localparam int LEN_W   = $clog2(ITEM_W + 1);
   localparam int ACC_W   = ((2 * ITEM_W + 16 + 7) / 8) * 8;
   localparam int SLOTS   = ACC_W / 8;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int CNT_W   = $clog2(ACC_W + 1);
   localparam int ACC_LIMIT = ACC_W - ITEM_W - 7;

   typedef struct packed {
      logic [EPOCH_W-1:0]       epoch;
      logic [MAX_CODE_BITS-1:0] code;
   } lcp_entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL
   } lcp_state_type;

endpackage

// ===== src/lzw_compress_packer_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzw_compress_packer_core
// LZW compressor with a child table in one synchronous memory, variable-width
// LSB-first code packing, stream header, clear code and end-of-stream flush.
// ---------------------------------------------------------------------------
//  channel | direction | tdata                | tlast
//  req_    | in        | [7:0] data_byte      | last_byte
//  rsp_    | out       | [7:0] out_byte       | end_of_stream
//
//  The child table is read in the accept cycle of a request, and the hit or
//  miss is resolved and written back in the next.
//  Bytes leave a bit accumulator one per cycle, unless rsp_tready is low;
//  a request is taken while bytes still wait, if the accumulator has room for
//  its codes. After reset a clearing pass sweeps all 2^20 table entries; table
//  clears bump an epoch tag, and every 1023rd clear repeats the clearing pass.
// ---------------------------------------------------------------------------
module lzw_compress_packer_core
   import lcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);

   lcp_state_type state_ff, state_in;

   logic [IDX_W-1:0]         clr_ff, clr_in;
   logic [EPOCH_W-1:0]       epoch_ff, epoch_in;
   logic [MAX_CODE_BITS-1:0] prefix_ff, prefix_in;
   logic [NFC_W-1:0]         nfc_ff, nfc_in;
   logic [CW_W-1:0]          width_ff, width_in;
   logic                     started_ff, started_in;
   logic [7:0]               byte_ff;
   logic                     last_ff;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [SLOTS-1:0]         eos_ff, eos_in;

   lcp_entry_type child_mem [TABLE_DEPTH];
   lcp_entry_type mem_rd_ff;
   lcp_entry_type mem_wdata;
   logic [IDX_W-1:0] mem_waddr;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;

   logic req_acc, in_eval, in_clear, clr_done;
   logic hit, miss, full, grow, tbl_clear;
   logic [CW_W-1:0]          width_mid;
   logic [NFC_W-1:0]         nfc_mid;
   logic [MAX_CODE_BITS-1:0] prefix_mid;
   logic [ITEM_W-1:0]        item_bits;
   logic [LEN_W-1:0]         item_len;
   logic                     pop;

   // -------------------------------------------------------------------------
   // child table
   // -------------------------------------------------------------------------
   assign rd_addr = {prefix_ff, req_tdata};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         child_mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= child_mem[rd_addr];
   end

   // -------------------------------------------------------------------------
   // state machine
   // -------------------------------------------------------------------------
   assign clr_done = (clr_ff == {IDX_W{1'b1}});

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (tbl_clear && (epoch_ff == {EPOCH_W{1'b1}})) begin
               state_in = ST_CLEAR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      in_eval    = 1'b0;
      in_clear   = 1'b0;
      case (state_ff)
         ST_CLEAR: in_clear = 1'b1;
         ST_IDLE:  req_tready = (cnt_ff <= CNT_W'(ACC_LIMIT));
         ST_EVAL:  in_eval = 1'b1;
         default:  in_clear = 1'b1;
      endcase
   end

   assign req_acc = req_tvalid && req_tready;

   // -------------------------------------------------------------------------
   // dictionary decision
   // -------------------------------------------------------------------------
   assign hit  = started_ff && (mem_rd_ff.epoch == epoch_ff);
   assign miss = started_ff && !hit;
   assign full = nfc_ff[NFC_W-1];
   assign grow = (nfc_ff == (NFC_W'(1) << width_ff)) &&
                 (width_ff < CW_W'(MAX_CODE_BITS));
   assign tbl_clear = last_ff || (miss && full);

   always_comb begin
      width_mid  = width_ff;
      nfc_mid    = nfc_ff;
      prefix_mid = hit ? mem_rd_ff.code : MAX_CODE_BITS'(byte_ff);
      if (miss) begin
         if (full) begin
            width_mid = CW_W'(MIN_WIDTH);
            nfc_mid   = NFC_W'(FIRST_FREE);
         end else begin
            nfc_mid = nfc_ff + NFC_W'(1);
            if (grow) begin
               width_mid = width_ff + CW_W'(1);
            end
         end
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = '0;
      if (in_clear) begin
         mem_we = 1'b1;
      end else if (in_eval && miss && !full) begin
         mem_we          = 1'b1;
         mem_waddr       = {prefix_ff, byte_ff};
         mem_wdata.epoch = epoch_ff;
         mem_wdata.code  = nfc_ff[MAX_CODE_BITS-1:0];
      end
   end

   // -------------------------------------------------------------------------
   // codes of one request
   // -------------------------------------------------------------------------
   always_comb begin
      logic [ITEM_W-1:0] mask_w;
      logic [ITEM_W-1:0] mask_m;
      mask_w    = ~({ITEM_W{1'b1}} << width_ff);
      mask_m    = ~({ITEM_W{1'b1}} << width_mid);
      item_bits = started_ff ? '0 : ITEM_W'(HDR_BITS);
      item_len  = started_ff ? '0 : LEN_W'(HDR_LEN);
      if (miss) begin
         item_bits = item_bits | ((ITEM_W'(prefix_ff) & mask_w) << item_len);
         item_len  = item_len + LEN_W'(width_ff);
         if (full) begin
            item_bits = item_bits | ((ITEM_W'(CLEAR_CODE) & mask_w) << item_len);
            item_len  = item_len + LEN_W'(width_ff);
         end
      end
      if (last_ff) begin
         item_bits = item_bits | ((ITEM_W'(prefix_mid) & mask_m) << item_len);
         item_len  = item_len + LEN_W'(width_mid);
      end
   end

   // -------------------------------------------------------------------------
   // bit accumulator and output
   // -------------------------------------------------------------------------
   assign rsp_tvalid = (cnt_ff >= CNT_W'(8));
   assign rsp_tdata  = acc_ff[7:0];
   assign rsp_tlast  = eos_ff[0];
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      logic [ACC_W-1:0] base_acc;
      logic [CNT_W-1:0] base_cnt;
      logic [SLOTS-1:0] base_eos;
      logic [CNT_W-1:0] sum;
      logic [SLOT_W-1:0] slot;
      base_acc = pop ? (acc_ff >> 8) : acc_ff;
      base_cnt = pop ? (cnt_ff - CNT_W'(8)) : cnt_ff;
      base_eos = pop ? (eos_ff >> 1) : eos_ff;
      sum      = base_cnt + CNT_W'(item_len);
      slot     = '0;
      acc_in   = base_acc;
      cnt_in   = base_cnt;
      eos_in   = base_eos;
      if (in_eval) begin
         acc_in = base_acc | (ACC_W'(item_bits) << base_cnt);
         if (last_ff) begin
            cnt_in = (sum + CNT_W'(7)) & ~CNT_W'(7);
            slot   = SLOT_W'((cnt_in >> 3) - CNT_W'(1));
            eos_in = base_eos | (SLOTS'(1) << slot);
         end else begin
            cnt_in = sum;
         end
      end
   end

   // -------------------------------------------------------------------------
   // next values of the dictionary state
   // -------------------------------------------------------------------------
   always_comb begin
      clr_in     = in_clear ? (clr_ff + IDX_W'(1)) : clr_ff;
      epoch_in   = epoch_ff;
      prefix_in  = prefix_ff;
      nfc_in     = nfc_ff;
      width_in   = width_ff;
      started_in = started_ff;
      if (in_clear && clr_done) begin
         epoch_in = EPOCH_W'(1);
      end
      if (in_eval) begin
         if (tbl_clear && (epoch_ff != {EPOCH_W{1'b1}})) begin
            epoch_in = epoch_ff + EPOCH_W'(1);
         end
         if (last_ff) begin
            prefix_in  = '0;
            nfc_in     = NFC_W'(FIRST_FREE);
            width_in   = CW_W'(MIN_WIDTH);
            started_in = 1'b0;
         end else begin
            prefix_in  = prefix_mid;
            nfc_in     = nfc_mid;
            width_in   = width_mid;
            started_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         byte_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         epoch_ff   <= '0;
         prefix_ff  <= '0;
         nfc_ff     <= NFC_W'(FIRST_FREE);
         width_ff   <= CW_W'(MIN_WIDTH);
         started_ff <= 1'b0;
         acc_ff     <= '0;
         cnt_ff     <= '0;
         eos_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         epoch_ff   <= epoch_in;
         prefix_ff  <= prefix_in;
         nfc_ff     <= nfc_in;
         width_ff   <= width_in;
         started_ff <= started_in;
         acc_ff     <= acc_in;
         cnt_ff     <= cnt_in;
         eos_ff     <= eos_in;
      end
   end

`ifndef SYNTH
   a_accept_then_eval: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_EVAL))
      else $error("request accepted without table evaluation");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(ACC_W))
      else $error("bit accumulator overflow");

   a_nfc_range: assert property (@(posedge clock) disable iff (reset)
      (nfc_ff >= NFC_W'(FIRST_FREE)) && (nfc_ff <= (NFC_W'(1) << MAX_CODE_BITS)))
      else $error("next free code out of range");

   a_width_range: assert property (@(posedge clock) disable iff (reset)
      (width_ff >= CW_W'(MIN_WIDTH)) && (width_ff <= CW_W'(MAX_CODE_BITS)))
      else $error("code width out of range");

   a_eos_valid: assert property (@(posedge clock) disable iff (reset)
      eos_ff[0] |-> rsp_tvalid)
      else $error("end of stream marked on an empty byte");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the LZW compressor core. A table of directed byte
// streams, then random streams and one long stream that widens the codes past
// 9 bits, are sent as requests in bursts. Every accepted request runs through
// an in-bench LZW packer whose output bytes are queued and compared in order
// against the response channel, which stalls on its own pattern and once
// holds off long enough to back up the core.
// ---------------------------------------------------------------------------
module tb;
   import lcp_pkg::*;

   localparam int DIRECTED_N   = 22;
   localparam int RANDOM_ITEMS = 100;
   localparam int LONG_STREAM  = 300;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 2500;
   localparam int DRAIN_CYCLES = 50;
   localparam int CYCLE_LIMIT  = 6000000;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [2:0]  nfix;
      logic [55:0] fix;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       eos;
   } out_byte_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] data_byte
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [7:0] out_byte
   logic       rsp_tlast;

   stim_row_type directed_rows [0:DIRECTED_N-1];
   out_byte_type expected_bytes [$];
   out_byte_type step_bytes [$];

   logic [MAX_CODE_BITS-1:0] dict [logic [IDX_W-1:0]];
   logic [MAX_CODE_BITS-1:0] lzw_prefix;
   logic [NFC_W-1:0]         lzw_next_free;
   logic [CW_W-1:0]          lzw_width;
   logic [6:0]               lzw_pend_bits;
   logic [2:0]               lzw_pend_cnt;
   logic                     lzw_started;

   int requests_sent;
   int results_seen;
   int mismatch_count;
   int burst_left;

   lzw_compress_packer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   task automatic record_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch: %s", what);
      end
   endtask

   task automatic append_step_byte(input logic [7:0] value);
      out_byte_type item;
      item.out_byte = value;
      item.eos      = 1'b0;
      step_bytes.insert(step_bytes.size(), item);
   endtask

   task automatic lzw_restart();
      dict.delete();
      lzw_prefix    = '0;
      lzw_next_free = NFC_W'(FIRST_FREE);
      lzw_width     = CW_W'(MIN_WIDTH);
      lzw_pend_bits = '0;
      lzw_pend_cnt  = '0;
      lzw_started   = 1'b0;
   endtask

   task automatic pack_code(input logic [MAX_CODE_BITS-1:0] code);
      logic [31:0] acc;
      int          n;
      acc = {25'd0, lzw_pend_bits}
            | ((32'(code) & ((32'd1 << lzw_width) - 32'd1)) << lzw_pend_cnt);
      n = int'(lzw_pend_cnt) + int'(lzw_width);
      while (n >= 8) begin
         append_step_byte(acc[7:0]);
         acc = acc >> 8;
         n -= 8;
      end
      lzw_pend_bits = acc[6:0];
      lzw_pend_cnt  = 3'(n);
   endtask

   task automatic predict_bytes(input logic [7:0] c, input logic last);
      logic [IDX_W-1:0] key;
      step_bytes.delete();
      if (!lzw_started) begin
         append_step_byte(8'h1F);
         append_step_byte(8'h9D);
         append_step_byte(8'(128 + MAX_CODE_BITS));
         lzw_prefix  = MAX_CODE_BITS'(c);
         lzw_started = 1'b1;
      end else begin
         key = {lzw_prefix, c};
         if (dict.exists(key)) begin
            lzw_prefix = dict[key];
         end else begin
            pack_code(lzw_prefix);
            if (int'(lzw_next_free) < (1 << MAX_CODE_BITS)) begin
               dict[key] = lzw_next_free[MAX_CODE_BITS-1:0];
               lzw_next_free = lzw_next_free + NFC_W'(1);
               if (int'(lzw_next_free) == (1 << lzw_width) + 1 &&
                   int'(lzw_width) < MAX_CODE_BITS) begin
                  lzw_width = lzw_width + CW_W'(1);
               end
            end else begin
               pack_code(MAX_CODE_BITS'(CLEAR_CODE));
               dict.delete();
               lzw_next_free = NFC_W'(FIRST_FREE);
               lzw_width     = CW_W'(MIN_WIDTH);
            end
            lzw_prefix = MAX_CODE_BITS'(c);
         end
      end
      if (last) begin
         pack_code(lzw_prefix);
         if (lzw_pend_cnt != 0) begin
            append_step_byte({1'b0, lzw_pend_bits});
         end
         step_bytes[step_bytes.size()-1].eos = 1'b1;
         lzw_restart();
      end
   endtask

   task automatic send_request(input logic [7:0] data, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      requests_sent++;
   endtask

   task automatic issue_byte(input logic [7:0] data, input logic last);
      send_request(data, last);
      predict_bytes(data, last);
      foreach (step_bytes[j]) expected_bytes.insert(expected_bytes.size(), step_bytes[j]);
   endtask

   // response stall pattern, with one long hold-off
   initial begin : receiver
      int  mode;
      int  seg;
      int  period;
      int  phase;
      bit  held;
      held = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         mode   = $urandom_range(0, 2);
         seg    = $urandom_range(20, 200);
         period = $urandom_range(2, 6);
         phase  = 0;
         repeat (seg) begin
            @(posedge clock);
            if (!held && requests_sent >= HOLD_AT) begin
               held = 1'b1;
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
            end
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: begin
                  rsp_tready <= (phase == 0);
                  phase = (phase + 1) % period;
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      out_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            record_mismatch($sformatf("result %0d with nothing expected: byte %02h last %0b",
                                      results_seen, rsp_tdata, rsp_tlast));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.out_byte || rsp_tlast !== want.eos) begin
               record_mismatch($sformatf(
                  "result %0d expected byte %02h last %0b, got byte %02h last %0b",
                  results_seen, want.out_byte, want.eos, rsp_tdata, rsp_tlast));
            end
         end
         results_seen++;
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      int           j;
      int           k;
      int           stream_len;
      bit           narrow;
      logic [7:0]   b;
      out_byte_type fixed_byte;

      directed_rows = '{
         '{8'hFF, 1'b1, 3'd5, 56'h000000FF8C9D1F},
         '{8'h00, 1'b1, 3'd5, 56'h000000008C9D1F},
         '{8'h00, 1'b0, 3'd3, 56'h000000008C9D1F},
         '{8'h00, 1'b1, 3'd3, 56'h00000000000000},
         '{8'h41, 1'b0, 3'd3, 56'h000000008C9D1F},
         '{8'h42, 1'b0, 3'd0, 56'h0},
         '{8'h41, 1'b0, 3'd0, 56'h0},
         '{8'h42, 1'b0, 3'd0, 56'h0},
         '{8'h41, 1'b0, 3'd0, 56'h0},
         '{8'h42, 1'b0, 3'd0, 56'h0},
         '{8'h41, 1'b0, 3'd0, 56'h0},
         '{8'h42, 1'b0, 3'd0, 56'h0},
         '{8'h41, 1'b1, 3'd0, 56'h0},
         '{8'hFF, 1'b0, 3'd0, 56'h0},
         '{8'h00, 1'b0, 3'd0, 56'h0},
         '{8'h80, 1'b0, 3'd0, 56'h0},
         '{8'h7F, 1'b0, 3'd0, 56'h0},
         '{8'h01, 1'b0, 3'd0, 56'h0},
         '{8'hFE, 1'b0, 3'd0, 56'h0},
         '{8'hFF, 1'b0, 3'd0, 56'h0},
         '{8'h00, 1'b0, 3'd0, 56'h0},
         '{8'hFF, 1'b1, 3'd0, 56'h0}
      };

      requests_sent  = 0;
      results_seen   = 0;
      mismatch_count = 0;
      burst_left     = 0;
      lzw_restart();

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (j = 0; j < DIRECTED_N; j++) begin
         if (directed_rows[j].nfix == 0) begin
            issue_byte(directed_rows[j].data, directed_rows[j].last);
         end else begin
            send_request(directed_rows[j].data, directed_rows[j].last);
            predict_bytes(directed_rows[j].data, directed_rows[j].last);
            for (k = 0; k < int'(directed_rows[j].nfix); k++) begin
               fixed_byte.out_byte = directed_rows[j].fix[8*k +: 8];
               fixed_byte.eos      = directed_rows[j].last &&
                                     (k == int'(directed_rows[j].nfix) - 1);
               expected_bytes.insert(expected_bytes.size(), fixed_byte);
            end
         end
      end

      while (requests_sent < DIRECTED_N + RANDOM_ITEMS) begin
         stream_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 24);
         narrow = 1'($urandom_range(0, 1));
         for (k = 0; k < stream_len; k++) begin
            b = narrow ? 8'h61 + 8'($urandom_range(0, 3)) : 8'($urandom);
            issue_byte(b, k == stream_len - 1);
         end
      end

      // grow the dictionary past 512 codes so the width steps up
      for (k = 0; k < LONG_STREAM; k++) begin
         issue_byte(8'($urandom), k == LONG_STREAM - 1);
      end
      req_tvalid <= 1'b0;

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         record_mismatch($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
      end

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
